// ===== src/segment_triangle_nearest_hit_unit_defines.svh =====
// Assertion macros shared by the checker of the segment/triangle hit unit.
// Each macro expects signals named clk and arst_n in the scope of its use.
`ifndef SEGMENT_TRIANGLE_NEAREST_HIT_UNIT_DEFINES_SVH
`define SEGMENT_TRIANGLE_NEAREST_HIT_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STNH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define STNH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/stnh_pkg.sv =====
// Shared types and constants of the segment/triangle nearest hit unit.
// No dependencies.
package stnh_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_START_X = 3'd0;
	localparam logic [2:0] REG_START_Y = 3'd1;
	localparam logic [2:0] REG_START_Z = 3'd2;
	localparam logic [2:0] REG_END_X = 3'd3;
	localparam logic [2:0] REG_END_Y = 3'd4;
	localparam logic [2:0] REG_END_Z = 3'd5;

	typedef struct packed {
		logic empty;
		logic [QCNT_W-1:0] count;
	} queue_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_FIN
	} back_state_t;

endpackage

// ===== src/stnh_front.sv =====
// Front part: accepts triangles and classifies them in a three-stage pipeline.
// Depends on stnh_pkg; feeds stnh_queue.
module stnh_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [COORD_BITS-1:0]          a [3],
	input  logic signed [COORD_BITS-1:0]          b [3],
	input  logic signed [COORD_BITS-1:0]          c [3],
	input  logic                                  last_triangle,
	input  logic signed [COORD_BITS-1:0]          seg_start [3],
	input  logic signed [COORD_BITS-1:0]          seg_end [3],
	input  stnh_pkg::queue_stat_t                 q_stat,
	output logic                                  ent_valid,
	output logic                                  ent_hit,
	output logic                                  ent_last,
	output logic [3*COORD_BITS+4:0]               ent_t,
	output logic [3*COORD_BITS+4:0]               ent_d
);
	import stnh_pkg::*;

	localparam int DIF_W = COORD_BITS + 1;
	localparam int PRX_W = 2 * DIF_W;
	localparam int CRS_W = 2 * COORD_BITS + 3;
	localparam int PRD_W = DIF_W + CRS_W;
	localparam int DOT_W = 3 * COORD_BITS + 6;

	function automatic logic signed [CRS_W-1:0] cross_term(
		input logic signed [DIF_W-1:0] p0, q0, p1, q1
	);
		logic signed [PRX_W-1:0] m0, m1;
		m0 = p0 * q0;
		m1 = p1 * q1;
		return CRS_W'(m0) - CRS_W'(m1);
	endfunction

	function automatic logic signed [DOT_W-1:0] dot3(
		input logic signed [DIF_W-1:0] p0, p1, p2,
		input logic signed [CRS_W-1:0] q0, q1, q2
	);
		logic signed [PRD_W-1:0] m0, m1, m2;
		m0 = p0 * q0;
		m1 = p1 * q1;
		m2 = p2 * q2;
		return DOT_W'(m0) + DOT_W'(m1) + DOT_W'(m2);
	endfunction

	logic                    accept;
	logic [QCNT_W:0]         occupancy;
	logic                    vld_s1, vld_s2, vld_s3;
	logic                    last_s1, last_s2, last_s3;
	logic signed [DIF_W-1:0] ab_s1 [3], ac_s1 [3], as_s1 [3], ray_s1 [3];
	logic signed [DIF_W-1:0] ab_s2 [3], ac_s2 [3], ray_s2 [3], as_s2 [3];
	logic signed [CRS_W-1:0] n_s2 [3], e_s2 [3];
	logic signed [DOT_W-1:0] d_s3, t_s3, v_s3, w_s3;
	logic signed [DOT_W:0]   vw_sum;

	// Items in the pipeline already own a queue slot.
	assign occupancy = (QCNT_W + 1)'(q_stat.count) + (QCNT_W + 1)'(vld_s1)
		+ (QCNT_W + 1)'(vld_s2) + (QCNT_W + 1)'(vld_s3);
	assign full = occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH);
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			ab_s1[k] <= DIF_W'(b[k]) - DIF_W'(a[k]);
			ac_s1[k] <= DIF_W'(c[k]) - DIF_W'(a[k]);
			as_s1[k] <= DIF_W'(seg_start[k]) - DIF_W'(a[k]);
			ray_s1[k] <= DIF_W'(seg_start[k]) - DIF_W'(seg_end[k]);
		end
		last_s1 <= last_triangle;

		n_s2[0] <= cross_term(ab_s1[1], ac_s1[2], ab_s1[2], ac_s1[1]);
		n_s2[1] <= cross_term(ab_s1[2], ac_s1[0], ab_s1[0], ac_s1[2]);
		n_s2[2] <= cross_term(ab_s1[0], ac_s1[1], ab_s1[1], ac_s1[0]);
		e_s2[0] <= cross_term(ray_s1[1], as_s1[2], ray_s1[2], as_s1[1]);
		e_s2[1] <= cross_term(ray_s1[2], as_s1[0], ray_s1[0], as_s1[2]);
		e_s2[2] <= cross_term(ray_s1[0], as_s1[1], ray_s1[1], as_s1[0]);
		ab_s2 <= ab_s1;
		ac_s2 <= ac_s1;
		as_s2 <= as_s1;
		ray_s2 <= ray_s1;
		last_s2 <= last_s1;

		d_s3 <= dot3(ray_s2[0], ray_s2[1], ray_s2[2], n_s2[0], n_s2[1], n_s2[2]);
		t_s3 <= dot3(as_s2[0], as_s2[1], as_s2[2], n_s2[0], n_s2[1], n_s2[2]);
		v_s3 <= dot3(ac_s2[0], ac_s2[1], ac_s2[2], e_s2[0], e_s2[1], e_s2[2]);
		w_s3 <= -dot3(ab_s2[0], ab_s2[1], ab_s2[2], e_s2[0], e_s2[1], e_s2[2]);
		last_s3 <= last_s2;
	end

	assign vw_sum = (DOT_W + 1)'(v_s3) + (DOT_W + 1)'(w_s3);

	always_comb begin
		ent_hit = (d_s3 > 0) && (t_s3 >= 0) && (t_s3 <= d_s3)
			&& (v_s3 >= 0) && (v_s3 <= d_s3) && (w_s3 >= 0)
			&& (vw_sum <= (DOT_W + 1)'(d_s3));
	end

	assign ent_valid = vld_s3;
	assign ent_last = last_s3;
	assign ent_t = t_s3[DOT_W-2:0];
	assign ent_d = d_s3[DOT_W-2:0];

endmodule

// ===== src/stnh_queue.sv =====
// Short register queue between the front and back parts.
// Depends on stnh_pkg for its depth and status type.
module stnh_queue #(
	parameter int WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [WIDTH-1:0]      wr_data,
	input  logic                  rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output stnh_pkg::queue_stat_t q_stat
);
	import stnh_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0]  slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + QCNT_W'(wr_en) - QCNT_W'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slot_q[wr_ptr_q] <= wr_data;
	end

	assign rd_data = slot_q[rd_ptr_q];
	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.count = cnt_q;

endmodule

// ===== src/stnh_back.sv =====
// Back part: restoring divider for the hit fraction and the running nearest hit.
// Depends on stnh_pkg; drains stnh_queue and holds the result register.
module stnh_back #(
	parameter int NUM_W = 53,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stnh_pkg::queue_stat_t q_stat,
	input  logic                  q_hit,
	input  logic                  q_last,
	input  logic [NUM_W-1:0]      q_t,
	input  logic [NUM_W-1:0]      q_d,
	output logic                  q_pop,
	input  logic                  pop,
	output logic                  empty,
	output logic                  tri_hit,
	output logic [T_FRAC_BITS:0]  tri_t,
	output logic [T_FRAC_BITS:0]  nearest_t,
	output logic                  any_hit,
	output logic                  last_result
);
	import stnh_pkg::*;

	localparam int CNT_W = $clog2(T_FRAC_BITS);
	localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

	back_state_t            state_q, state_d;
	logic                   load, step, finish;
	logic                   hit_q, last_q;
	logic [NUM_W-1:0]       den_q, rem_q;
	logic [T_FRAC_BITS:0]   quo_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   out_valid_q;
	logic [T_FRAC_BITS:0]   best_q;
	logic                   seen_q;
	logic [NUM_W:0]         rem_sh;
	logic                   rem_ge;
	logic                   t_ge;
	logic [T_FRAC_BITS:0]   frac, new_best;
	logic                   new_seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		load = 1'b0;
		step = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					load = 1'b1;
					state_d = q_hit ? BK_DIV : BK_FIN;
				end
			end
			BK_DIV: begin
				step = 1'b1;
				if (cnt_q == CNT_W'(T_FRAC_BITS - 1)) state_d = BK_FIN;
			end
			BK_FIN: begin
				if (!out_valid_q || pop) begin
					finish = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign q_pop = load;

	// One quotient bit per cycle.
	assign t_ge = q_t >= q_d;
	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (load) begin
			hit_q <= q_hit;
			last_q <= q_last;
			den_q <= q_d;
			rem_q <= t_ge ? q_t - q_d : q_t;
			quo_q <= (T_FRAC_BITS + 1)'(t_ge);
			cnt_q <= '0;
		end else if (step) begin
			rem_q <= rem_ge ? NUM_W'(rem_sh - {1'b0, den_q}) : NUM_W'(rem_sh);
			quo_q <= {quo_q[T_FRAC_BITS-1:0], rem_ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign frac = hit_q ? quo_q : '0;
	assign new_best = (hit_q && (frac < best_q)) ? frac : best_q;
	assign new_seen = seen_q || hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			best_q <= T_ONE;
			seen_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
				best_q <= last_q ? T_ONE : new_best;
				seen_q <= last_q ? 1'b0 : new_seen;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			tri_hit <= hit_q;
			tri_t <= frac;
			nearest_t <= new_best;
			any_hit <= new_seen;
			last_result <= last_q;
		end
	end

	assign empty = !out_valid_q;

endmodule

// ===== src/segment_triangle_nearest_hit_unit.sv =====
// Segment/triangle nearest hit unit. Each triangle goes through the front pipeline and
// the queue; the back part then sends a miss straight to its finish state, runs the
// divider first for a hit, and writes the result register. The back-end divider takes
// a new queue entry only when done with the last one. The front accepts an item per cycle
// until its four-entry queue is spoken for. Reset (arst_n low, asynchronous) clears
// the segment registers to 0, the nearest fraction to 1.0 and the hit flag.
// Depends on stnh_pkg, stnh_front, stnh_queue and stnh_back.
module segment_triangle_nearest_hit_unit #(
	parameter int COORD_BITS = 16,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Triangle input queue.
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] a_z,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] b_z,
	input  logic signed [COORD_BITS-1:0] c_x,
	input  logic signed [COORD_BITS-1:0] c_y,
	input  logic signed [COORD_BITS-1:0] c_z,
	input  logic                         last_triangle,
	// Result queue.
	output logic                         empty,
	input  logic                         pop,
	output logic                         tri_hit,
	output logic [T_FRAC_BITS:0]         tri_t,
	output logic [T_FRAC_BITS:0]         nearest_t,
	output logic                         any_hit,
	output logic                         last_result,
	// Configuration port.
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [4:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import stnh_pkg::*;

	// The hit tests keep exact products; t and d are non-negative on a hit.
	localparam int NUM_W = 3 * COORD_BITS + 5;
	localparam int ENT_W = 2 * NUM_W + 2;

	logic signed [COORD_BITS-1:0] seg_start [3];
	logic signed [COORD_BITS-1:0] seg_end [3];
	logic signed [COORD_BITS-1:0] vtx_a [3], vtx_b [3], vtx_c [3];
	logic [2:0]                   reg_idx;
	logic                         cfg_write;

	queue_stat_t      q_stat;
	logic             ent_valid, ent_hit, ent_last;
	logic [NUM_W-1:0] ent_t, ent_d;
	logic [ENT_W-1:0] q_wdata, q_rdata;
	logic             q_pop;

	// The register index sits above the two byte-offset bits.
	assign reg_idx = paddr[4:2];
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				seg_start[k] <= '0;
				seg_end[k] <= '0;
			end
		end else if (cfg_write) begin
			case (reg_idx)
				REG_START_X: seg_start[0] <= pwdata[COORD_BITS-1:0];
				REG_START_Y: seg_start[1] <= pwdata[COORD_BITS-1:0];
				REG_START_Z: seg_start[2] <= pwdata[COORD_BITS-1:0];
				REG_END_X:   seg_end[0] <= pwdata[COORD_BITS-1:0];
				REG_END_Y:   seg_end[1] <= pwdata[COORD_BITS-1:0];
				REG_END_Z:   seg_end[2] <= pwdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Reads return the stored coordinate zero-extended; unused addresses read as zero.
	always_comb begin
		case (reg_idx)
			REG_START_X: prdata = 32'(unsigned'(seg_start[0]));
			REG_START_Y: prdata = 32'(unsigned'(seg_start[1]));
			REG_START_Z: prdata = 32'(unsigned'(seg_start[2]));
			REG_END_X:   prdata = 32'(unsigned'(seg_end[0]));
			REG_END_Y:   prdata = 32'(unsigned'(seg_end[1]));
			REG_END_Z:   prdata = 32'(unsigned'(seg_end[2]));
			default:     prdata = '0;
		endcase
	end

	assign vtx_a[0] = a_x;
	assign vtx_a[1] = a_y;
	assign vtx_a[2] = a_z;
	assign vtx_b[0] = b_x;
	assign vtx_b[1] = b_y;
	assign vtx_b[2] = b_z;
	assign vtx_c[0] = c_x;
	assign vtx_c[1] = c_y;
	assign vtx_c[2] = c_z;

	// The front classifies each triangle; full also counts items still in its pipeline.
	stnh_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.a(vtx_a),
		.b(vtx_b),
		.c(vtx_c),
		.last_triangle(last_triangle),
		.seg_start(seg_start),
		.seg_end(seg_end),
		.q_stat(q_stat),
		.ent_valid(ent_valid),
		.ent_hit(ent_hit),
		.ent_last(ent_last),
		.ent_t(ent_t),
		.ent_d(ent_d)
	);

	assign q_wdata = {ent_hit, ent_last, ent_t, ent_d};

	stnh_queue #(
		.WIDTH(ENT_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(ent_valid),
		.wr_data(q_wdata),
		.rd_en(q_pop),
		.rd_data(q_rdata),
		.q_stat(q_stat)
	);

	// The back divides t by d for hits and keeps the running nearest fraction.
	stnh_back #(
		.NUM_W(NUM_W),
		.T_FRAC_BITS(T_FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.q_hit(q_rdata[ENT_W-1]),
		.q_last(q_rdata[ENT_W-2]),
		.q_t(q_rdata[2*NUM_W-1:NUM_W]),
		.q_d(q_rdata[NUM_W-1:0]),
		.q_pop(q_pop),
		.pop(pop),
		.empty(empty),
		.tri_hit(tri_hit),
		.tri_t(tri_t),
		.nearest_t(nearest_t),
		.any_hit(any_hit),
		.last_result(last_result)
	);

endmodule

// ===== src/stnh_checker.sv =====
// Port-level checker for the segment/triangle nearest hit unit, bound to the top level.
// Depends on segment_triangle_nearest_hit_unit_defines.svh.
`include "segment_triangle_nearest_hit_unit_defines.svh"

module stnh_checker #(
	parameter int T_FRAC_BITS = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 pop,
	input logic                 empty,
	input logic                 tri_hit,
	input logic [T_FRAC_BITS:0] tri_t,
	input logic [T_FRAC_BITS:0] nearest_t,
	input logic                 any_hit
);
	localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

	`STNH_ASSERT_NXT(a_result_held, !empty && !pop, !empty && $stable(tri_t), "result dropped while stalled")
	`STNH_ASSERT_IMP(a_miss_zero, !empty && !tri_hit, tri_t == '0, "miss with a nonzero fraction")
	`STNH_ASSERT_IMP(a_hit_nearest, !empty && tri_hit, any_hit && (nearest_t <= tri_t), "hit not folded into nearest")
	`STNH_ASSERT_IMP(a_no_hit_one, !empty && !any_hit, nearest_t == T_ONE, "nearest moved without a hit")

endmodule

bind segment_triangle_nearest_hit_unit stnh_checker #(
	.T_FRAC_BITS(T_FRAC_BITS)
) u_stnh_checker (.*);
